### rtl/core/spring_network_energy_gradient_defines.svh
// Assertion macros shared by the spring network RTL.
// Both macros expect signals named clk and arst_n in the using module.
`ifndef SPRING_NETWORK_ENERGY_GRADIENT_DEFINES_SVH
`define SPRING_NETWORK_ENERGY_GRADIENT_DEFINES_SVH
`ifndef SYNTHESIS
`define SNEG_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("spring network check failed");
`define SNEG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("spring network sequencing check failed");
`else
`define SNEG_ASSERT(lbl, prop)
`define SNEG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/snet_pkg.sv
package snet_pkg;

	// Node store size and index width.
	localparam int MAX_NODES = 1024;
	localparam int NODE_W = $clog2(MAX_NODES);

	// Saturation limits of the accumulators.
	localparam logic [47:0] EMAX = 48'hFFFF_FFFF_FFFF;
	localparam logic signed [49:0] GMAX = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [49:0] GMIN = -50'sh0_8000_0000_0000;
	localparam logic [47:0] GCAP = 48'h8000_0000_0000;

	// Item function codes.
	typedef enum logic [1:0] {
		FN_LOAD   = 2'd0,
		FN_SPRING = 2'd1,
		FN_READ   = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE, ST_LOAD, ST_CLEAR, ST_RGA, ST_RRES,
		ST_RPA, ST_RPB, ST_DIFF, ST_SQX, ST_SQY, ST_SUM, ST_SQRT, ST_STRETCH,
		ST_KMS, ST_E_LO, ST_E_HI, ST_E_SUM, ST_E_ACC, ST_DIV,
		ST_GX_LO, ST_GX_HI, ST_GY_LO, ST_GY_HI, ST_GY_FIN,
		ST_UPD_A, ST_RGB, ST_UPD_B, ST_DONE
	} state_t;

endpackage

### rtl/core/spring_network_energy_gradient.sv
// An item holds the block from its accepting cycle until its result is loaded;
// a stalled result holds it longer.
// Throughput: one item at a time; the 32-step square root and the 17-step direction
// divider set the spring time, with one shared 33x33 multiplier for all products.
// Reset clears the sequencer, the output valid and the energy accumulator; node
// positions and gradients are undefined until a load item writes them.
`include "spring_network_energy_gradient_defines.svh"
module spring_network_energy_gradient
	import snet_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [9:0]         node_a,
	input  logic [9:0]         node_b,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	input  logic [31:0]        stiffness,
	input  logic [31:0]        rest_length,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [47:0] grad_x,
	output logic signed [47:0] grad_y,
	output logic [47:0]        energy,
	output logic               degenerate
);

	state_t state_q, state_d;

	// Latched item.
	func_t             func_q;
	logic [NODE_W-1:0] a_q, b_q;
	logic [31:0]       x_q, y_q, k_q, rest_q, sx_q, sy_q;

	// Spring datapath registers.
	logic [63:0]        pa_q;
	logic [31:0]        adx_q, ady_q;
	logic               dxn_q, dyn_q;
	logic [65:0]        mul_q, pl_q;
	logic [63:0]        rad_q;
	logic [31:0]        root_q;
	logic [33:0]        rem_q;
	logic [4:0]         cnt_q;
	logic               sneg_q;
	logic [32:0]        ms_q;
	logic [64:0]        km_q;
	logic [47:0]        e_q;
	logic [32:0]        remx_q, remy_q;
	logic [16:0]        dvx_q, dvy_q, cx_q, cy_q;
	logic signed [49:0] gx_q, gy_q;
	logic [47:0]        energy_q;
	logic signed [47:0] res_gx_q, res_gy_q;
	logic               res_deg_q;

	// Output stage.
	logic               out_valid_q;
	logic signed [47:0] gx_out_q, gy_out_q;
	logic [47:0]        en_out_q;
	logic               deg_out_q;

	// Memories: positions {x, y} and gradients {gx, gy}.
	logic [63:0] pos_mem [MAX_NODES];
	logic [95:0] grad_mem [MAX_NODES];
	logic [63:0] pos_rd_q;
	logic [95:0] grad_rd_q;

	logic              pos_re, pos_we, grad_re, grad_we;
	logic [NODE_W-1:0] pos_raddr, grad_raddr, grad_waddr;
	logic [95:0]       grad_wdata;

	logic [32:0] mul_a, mul_b;
	logic [65:0] mul_p;

	// Energy term floor(hi*2^32 + lo) / 2^33, saturated.
	function automatic logic [47:0] energy_term(input logic [65:0] ph, input logic [65:0] pl);
		logic [97:0] prod;
		prod = {ph[65:0], 32'd0} + {32'd0, pl};
		if (prod[97:81] != '0) begin
			return EMAX;
		end
		return prod[80:33];
	endfunction

	// Signed gradient term: product shifted by 32, capped at 2^47.
	function automatic logic signed [49:0] grad_term(input logic [65:0] ph,
		input logic [65:0] pl, input logic neg);
		logic [97:0] prod;
		logic [47:0] mag;
		prod = {ph[65:0], 32'd0} + {32'd0, pl};
		if (prod[97:80] != '0 || prod[79:32] > GCAP) begin
			mag = GCAP;
		end else begin
			mag = prod[79:32];
		end
		return neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
	endfunction

	// Saturating gradient accumulate.
	function automatic logic signed [47:0] sat_grad(input logic signed [47:0] acc,
		input logic signed [49:0] d);
		logic signed [49:0] s;
		s = {{2{acc[47]}}, acc} + d;
		if (s > GMAX) begin
			return GMAX[47:0];
		end
		if (s < GMIN) begin
			return GMIN[47:0];
		end
		return s[47:0];
	endfunction

	// Combinational datapath pieces.
	logic signed [33:0] dfx, dfy;
	logic signed [31:0] dxc, dyc;
	logic [35:0] rem_sh, trial;
	logic [32:0] sd;
	logic [32:0] remx_sh, remy_sh, len33;
	logic [48:0] en_sum;
	logic signed [47:0] nga_x, nga_y, ngb_x, ngb_y;

	always_comb begin
		dfx = {{2{pa_q[63]}}, pa_q[63:32]} - {{2{pos_rd_q[63]}}, pos_rd_q[63:32]}
			- {{2{sx_q[31]}}, sx_q};
		dfy = {{2{pa_q[31]}}, pa_q[31:0]} - {{2{pos_rd_q[31]}}, pos_rd_q[31:0]}
			- {{2{sy_q[31]}}, sy_q};
		dxc = (dfx > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
			(dfx < -34'sh0_8000_0000) ? 32'sh8000_0000 : dfx[31:0];
		dyc = (dfy > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
			(dfy < -34'sh0_8000_0000) ? 32'sh8000_0000 : dfy[31:0];
		rem_sh = {rem_q, rad_q[63:62]};
		trial = {2'b00, root_q, 2'b01};
		sd = {1'b0, root_q} - {1'b0, rest_q};
		len33 = {1'b0, root_q};
		remx_sh = {remx_q[31:0], dvx_q[16]};
		remy_sh = {remy_q[31:0], dvy_q[16]};
		en_sum = {1'b0, energy_q} + {1'b0, e_q};
		nga_x = sat_grad(grad_rd_q[95:48], gx_q);
		nga_y = sat_grad(grad_rd_q[47:0], gy_q);
		ngb_x = sat_grad(grad_rd_q[95:48], -gx_q);
		ngb_y = sat_grad(grad_rd_q[47:0], -gy_q);
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQX: begin
				mul_a = {1'b0, adx_q};
				mul_b = {1'b0, adx_q};
			end
			ST_SQY: begin
				mul_a = {1'b0, ady_q};
				mul_b = {1'b0, ady_q};
			end
			ST_KMS: begin
				mul_a = ms_q;
				mul_b = {1'b0, k_q};
			end
			ST_E_LO: begin
				mul_a = {1'b0, mul_q[31:0]};
				mul_b = ms_q;
			end
			ST_E_HI: begin
				mul_a = km_q[64:32];
				mul_b = ms_q;
			end
			ST_GX_LO: begin
				mul_a = {1'b0, km_q[31:0]};
				mul_b = {16'd0, cx_q};
			end
			ST_GX_HI: begin
				mul_a = km_q[64:32];
				mul_b = {16'd0, cx_q};
			end
			ST_GY_LO: begin
				mul_a = {1'b0, km_q[31:0]};
				mul_b = {16'd0, cy_q};
			end
			ST_GY_HI: begin
				mul_a = km_q[64:32];
				mul_b = {16'd0, cy_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (func_t'(func))
						FN_LOAD:   state_d = ST_LOAD;
						FN_SPRING: state_d = ST_RPA;
						FN_READ:   state_d = ST_RGA;
						FN_CLEAR:  state_d = ST_CLEAR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD:    state_d = ST_DONE;
			// A clear item still reports the gradient of its node.
			ST_CLEAR:   state_d = ST_RGA;
			ST_RGA:     state_d = ST_RRES;
			ST_RRES:    state_d = ST_DONE;
			ST_RPA:     state_d = ST_RPB;
			ST_RPB:     state_d = ST_DIFF;
			ST_DIFF:    state_d = ST_SQX;
			ST_SQX:     state_d = ST_SQY;
			ST_SQY:     state_d = ST_SUM;
			ST_SUM:     state_d = ST_SQRT;
			ST_SQRT:    state_d = (cnt_q == '0) ? ST_STRETCH : ST_SQRT;
			ST_STRETCH: state_d = ST_KMS;
			ST_KMS:     state_d = ST_E_LO;
			ST_E_LO:    state_d = ST_E_HI;
			ST_E_HI:    state_d = ST_E_SUM;
			ST_E_SUM:   state_d = ST_E_ACC;
			ST_E_ACC:   state_d = res_deg_q ? ST_RGA : ST_DIV;
			ST_DIV:     state_d = (cnt_q == '0) ? ST_GX_LO : ST_DIV;
			ST_GX_LO:   state_d = ST_GX_HI;
			ST_GX_HI:   state_d = ST_GY_LO;
			ST_GY_LO:   state_d = ST_GY_HI;
			ST_GY_HI:   state_d = ST_GY_FIN;
			ST_GY_FIN:  state_d = ST_UPD_A;
			ST_UPD_A:   state_d = ST_RGB;
			ST_RGB:     state_d = ST_UPD_B;
			ST_UPD_B:   state_d = ST_DONE;
			ST_DONE:    state_d = (!out_valid_q || out_ready) ? ST_IDLE : ST_DONE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		pos_re = 1'b0;
		pos_we = 1'b0;
		pos_raddr = a_q;
		grad_re = 1'b0;
		grad_we = 1'b0;
		grad_raddr = a_q;
		grad_waddr = a_q;
		grad_wdata = '0;
		unique case (state_q)
			ST_LOAD: begin
				pos_we = 1'b1;
				grad_we = 1'b1;
			end
			ST_RPA: pos_re = 1'b1;
			ST_RPB: begin
				pos_re = 1'b1;
				pos_raddr = b_q;
			end
			ST_RGA, ST_GY_FIN: grad_re = 1'b1;
			ST_UPD_A: begin
				grad_we = 1'b1;
				grad_wdata = {nga_x, nga_y};
			end
			ST_RGB: begin
				grad_re = 1'b1;
				grad_raddr = b_q;
			end
			ST_UPD_B: begin
				grad_we = 1'b1;
				grad_waddr = b_q;
				grad_wdata = {ngb_x, ngb_y};
			end
			default: begin
				pos_re = 1'b0;
			end
		endcase
	end

	// Position and gradient memories with registered reads.
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[a_q] <= {x_q, y_q};
		end
		if (pos_re) begin
			pos_rd_q <= pos_mem[pos_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (grad_we) begin
			grad_mem[grad_waddr] <= grad_wdata;
		end
		if (grad_re) begin
			grad_rd_q <= grad_mem[grad_raddr];
		end
	end

	// Control state: sequencer, energy accumulator and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			energy_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				energy_q <= '0;
			end else if (state_q == ST_E_ACC) begin
				energy_q <= en_sum[48] ? EMAX : en_sum[47:0];
			end
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload datapath.
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		unique case (state_q)
			ST_IDLE: begin
				func_q <= func_t'(func);
				a_q <= node_a[NODE_W-1:0];
				b_q <= node_b[NODE_W-1:0];
				x_q <= x_value;
				y_q <= y_value;
				k_q <= stiffness;
				rest_q <= rest_length;
				sx_q <= shift_x;
				sy_q <= shift_y;
				res_deg_q <= 1'b0;
			end
			ST_LOAD: begin
				res_gx_q <= '0;
				res_gy_q <= '0;
			end
			ST_RRES: begin
				res_gx_q <= grad_rd_q[95:48];
				res_gy_q <= grad_rd_q[47:0];
			end
			ST_RPB: pa_q <= pos_rd_q;
			ST_DIFF: begin
				dxn_q <= dxc[31];
				dyn_q <= dyc[31];
				adx_q <= dxc[31] ? 32'(-dxc) : 32'(dxc);
				ady_q <= dyc[31] ? 32'(-dyc) : 32'(dyc);
			end
			ST_SQY: rad_q <= mul_q[63:0];
			ST_SUM: begin
				rad_q <= rad_q + mul_q[63:0];
				root_q <= '0;
				rem_q <= '0;
				cnt_q <= 5'd31;
			end
			// One result bit of the square root per cycle.
			ST_SQRT: begin
				rad_q <= {rad_q[61:0], 2'b00};
				cnt_q <= cnt_q - 5'd1;
				if (rem_sh >= trial) begin
					rem_q <= 34'(rem_sh - trial);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh[33:0];
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			ST_STRETCH: begin
				sneg_q <= sd[32];
				ms_q <= sd[32] ? 33'(-sd) : sd;
				res_deg_q <= (root_q == '0);
				remx_q <= {2'b00, adx_q[31:1]};
				remy_q <= {2'b00, ady_q[31:1]};
				dvx_q <= {adx_q[0], 16'd0};
				dvy_q <= {ady_q[0], 16'd0};
				cx_q <= '0;
				cy_q <= '0;
				cnt_q <= 5'd16;
			end
			ST_E_LO: km_q <= mul_q[64:0];
			ST_E_HI: pl_q <= mul_q;
			ST_E_SUM: e_q <= energy_term(mul_q, pl_q);
			// Both direction quotients, one bit each per cycle.
			ST_DIV: begin
				cnt_q <= cnt_q - 5'd1;
				dvx_q <= {dvx_q[15:0], 1'b0};
				dvy_q <= {dvy_q[15:0], 1'b0};
				if (remx_sh >= len33) begin
					remx_q <= remx_sh - len33;
					cx_q <= {cx_q[15:0], 1'b1};
				end else begin
					remx_q <= remx_sh;
					cx_q <= {cx_q[15:0], 1'b0};
				end
				if (remy_sh >= len33) begin
					remy_q <= remy_sh - len33;
					cy_q <= {cy_q[15:0], 1'b1};
				end else begin
					remy_q <= remy_sh;
					cy_q <= {cy_q[15:0], 1'b0};
				end
			end
			ST_GX_HI: pl_q <= mul_q;
			ST_GY_LO: gx_q <= grad_term(mul_q, pl_q, sneg_q ^ dxn_q);
			ST_GY_HI: pl_q <= mul_q;
			ST_GY_FIN: gy_q <= grad_term(mul_q, pl_q, sneg_q ^ dyn_q);
			ST_UPD_A: begin
				res_gx_q <= nga_x;
				res_gy_q <= nga_y;
			end
			// Same node at both ends reports the second update.
			ST_UPD_B: begin
				if (a_q == b_q) begin
					res_gx_q <= ngb_x;
					res_gy_q <= ngb_y;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					gx_out_q <= res_gx_q;
					gy_out_q <= res_gy_q;
					en_out_q <= energy_q;
					deg_out_q <= res_deg_q && (func_q == FN_SPRING);
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign grad_x = gx_out_q;
	assign grad_y = gy_out_q;
	assign energy = en_out_q;
	assign degenerate = deg_out_q;

	// Checks on the sequencer and the divider.
	`SNEG_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready)
	`SNEG_ASSERT(a_div_nonzero_len, (state_q == ST_DIV) |-> (root_q != '0))
	`SNEG_ASSERT(a_div_rem_bound, (state_q == ST_DIV) |-> (remx_q < len33) && (remy_q < len33))
	`SNEG_ASSERT_NEXT(a_result_after_done, (state_q == ST_DONE) && (!out_valid_q || out_ready), out_valid)

endmodule
